// ===== hw/rtl/bes_pkg.sv =====
// Package for the beacon element scanner.
// Holds the parser phase type, element identifiers, the vendor OUI and the result record.
// No dependencies.
`default_nettype none

package bes_pkg;

  // Phases of the byte parser.
  typedef enum logic [1:0] {
    PH_FIXED = 2'd0,
    PH_TYPE  = 2'd1,
    PH_LEN   = 2'd2,
    PH_VALUE = 2'd3
  } phase_e;

  // Element identifiers that the scanner looks for.
  localparam logic [7:0] ID_DS     = 8'd3;
  localparam logic [7:0] ID_TIM    = 8'd5;
  localparam logic [7:0] ID_VENDOR = 8'd221;

  // Fixed-field bytes between the management header and the first element.
  localparam int FIXED_FIELD_BYTES = 12;

  // Offset of the beacon interval inside the fixed fields.
  localparam int INTERVAL_FIELD_OFS = 8;

  // Interval reported for an unusable frame.
  localparam logic [15:0] DEFAULT_INTERVAL = 16'h0064;

  // Vendor OUI plus type byte that marks the element of interest.
  function automatic logic [7:0] oui_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h00;
      2'd1:    val = 8'h09;
      2'd2:    val = 8'hBF;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // One result record.
  typedef struct packed {
    logic        beacon_valid;
    logic [15:0] beacon_interval;
    logic        channel_found;
    logic [15:0] channel_addr;
    logic        tim_found;
    logic [8:0]  tim_offset;
    logic [7:0]  listen_interval;
    logic        vendor_found;
    logic [15:0] vendor_info_addr;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/beacon_element_scanner.sv =====
// Beacon element scanner: parses a stored beacon frame one byte per transaction.
// Depends on bes_pkg for the phase type, element identifiers and result record.
// Throughput: one frame byte accepted every cycle while the skid register is empty.
// The result of a frame is registered in the output register, or in a one-entry skid
// register while the output is stalled. Reset clears the parser, the base address and
// both result valid flags; a finished frame returns the parser to its reset state.
`default_nettype none

module beacon_element_scanner
  import bes_pkg::*;
#(
  parameter int TX_HEADER_BYTES     = 12,
  parameter int MAC_HEADER_BYTES    = 24,
  parameter int MAX_FRAME_BYTES     = 512,
  parameter int VENDOR_MIN_LEN      = 8,
  parameter int VENDOR_EXTRA_OFFSET = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration register
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_last_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             beacon_valid_o,
  output logic [15:0]      beacon_interval_o,
  output logic             channel_found_o,
  output logic [15:0]      channel_addr_o,
  output logic             tim_found_o,
  output logic [8:0]       tim_offset_o,
  output logic [7:0]       listen_interval_o,
  output logic             vendor_found_o,
  output logic [15:0]      vendor_info_addr_o
);

  // Frame geometry.
  localparam logic [31:0] HdrBytes    = 32'(TX_HEADER_BYTES + MAC_HEADER_BYTES);
  localparam logic [31:0] ElemStart   = 32'(TX_HEADER_BYTES + MAC_HEADER_BYTES
                                            + FIXED_FIELD_BYTES);
  localparam logic [31:0] IntervalPos = 32'(((TX_HEADER_BYTES + MAC_HEADER_BYTES
                                              + INTERVAL_FIELD_OFS) / 2) * 2);
  localparam logic [31:0] MaxBytes    = 32'(MAX_FRAME_BYTES);
  // Position counts up to the maximum; a value start may lie one past it, the listen position two.
  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int VW = $clog2(MAX_FRAME_BYTES + 3);

  logic          accept;
  logic [15:0]   base_q;

  // Parser state.
  logic [PW-1:0] pos_q, pos_d;
  phase_e        phase_q, phase_d;
  logic [7:0]    type_q, type_d;
  logic [7:0]    remain_q, remain_d;
  logic [VW-1:0] vstart_q, vstart_d;
  logic [2:0]    vidx_q, vidx_d;
  logic          oui_q, oui_d;
  logic [15:0]   interval_q, interval_d;
  logic [2:0]    found_q, found_d;
  logic [15:0]   chan_q, chan_d;
  logic [8:0]    tim_q, tim_d;
  logic [7:0]    listen_q, listen_d;
  logic [15:0]   vaddr_q, vaddr_d;
  logic          too_long_q, too_long_d;
  logic          lpend_q, lpend_d;
  logic [VW-1:0] lpos_q, lpos_d;

  logic          start_elem;
  logic [VW-1:0] start_vstart;
  logic [7:0]    start_len;
  logic          vhit;
  logic          oui_ok;
  logic          frame_ok;
  res_t          res_new;

  // Result slots.
  res_t          out_q, skid_q;
  logic          out_valid_q, skid_valid_q;
  logic          out_ready;

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = skid_valid_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Next parser state for the byte on the input, including end-of-frame wrap-up.
  always_comb begin
    pos_d        = pos_q;
    phase_d      = phase_q;
    type_d       = type_q;
    remain_d     = remain_q;
    vstart_d     = vstart_q;
    vidx_d       = vidx_q;
    oui_d        = oui_q;
    interval_d   = interval_q;
    found_d      = found_q;
    chan_d       = chan_q;
    tim_d        = tim_q;
    listen_d     = listen_q;
    vaddr_d      = vaddr_q;
    too_long_d   = too_long_q;
    lpend_d      = lpend_q;
    lpos_d       = lpos_q;
    start_elem   = 1'b0;
    start_vstart = VW'(pos_q) + VW'(1);
    start_len    = frame_byte_i;
    vhit         = 1'b0;
    oui_ok       = 1'b0;

    if (32'(pos_q) < MaxBytes) begin
      // Pending capture of the byte after the TIM value start.
      if (lpend_q && (VW'(pos_q) == lpos_q)) begin
        listen_d = frame_byte_i;
        lpend_d  = 1'b0;
      end
      // Little-endian beacon interval.
      if (32'(pos_q) == IntervalPos) begin
        interval_d[7:0] = frame_byte_i;
      end
      if (32'(pos_q) == IntervalPos + 32'd1) begin
        interval_d[15:8] = frame_byte_i;
      end

      case (phase_q)
        PH_FIXED: begin
          if (32'(pos_q) + 32'd1 >= ElemStart) begin
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_d  = frame_byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          start_elem = 1'b1;
        end
        PH_VALUE: begin
          if ((type_q == ID_VENDOR) && (vidx_q < 3'd4)) begin
            oui_ok = oui_q && (frame_byte_i == oui_byte(vidx_q[1:0]));
            oui_d  = oui_ok;
            if ((vidx_q == 3'd3) && oui_ok) begin
              vhit = 1'b1;
            end
          end
          if (vidx_q < 3'd4) begin
            vidx_d = vidx_q + 3'd1;
          end
          remain_d = remain_q - 8'd1;
          if (remain_d == 8'd0) begin
            phase_d = PH_TYPE;
          end
        end
        default: begin
          phase_d = PH_FIXED;
        end
      endcase
      pos_d = pos_q + PW'(1);
    end else begin
      too_long_d = 1'b1;
    end

    // Wrap-up on the last byte: a dangling type byte or a vendor element cut short.
    if (frame_last_i && !too_long_d) begin
      if ((phase_d == PH_LEN) && !start_elem) begin
        start_elem   = 1'b1;
        start_vstart = VW'(pos_d) + VW'(1);
        start_len    = 8'd0;
      end else if ((phase_d == PH_VALUE) && (type_d == ID_VENDOR) && oui_d
                   && (vidx_d == 3'd3)) begin
        vhit = 1'b1;
      end
    end

    // Element header complete: record the value start and capture known elements.
    if (start_elem) begin
      remain_d = start_len;
      vstart_d = start_vstart;
      vidx_d   = 3'd0;
      oui_d    = (32'(start_len) >= 32'(VENDOR_MIN_LEN));
      if (type_d == ID_DS) begin
        found_d[0] = 1'b1;
        chan_d     = base_q + 16'(start_vstart);
      end else if (type_d == ID_TIM) begin
        found_d[1] = 1'b1;
        tim_d      = 9'(32'(start_vstart) - HdrBytes);
        listen_d   = 8'd0;
        lpend_d    = 1'b1;
        lpos_d     = start_vstart + VW'(1);
      end
      phase_d = (start_len != 8'd0) ? PH_VALUE : PH_TYPE;
    end

    // Matching vendor element.
    if (vhit) begin
      found_d[2] = 1'b1;
      vaddr_d    = base_q + 16'(vstart_d) + 16'(VENDOR_EXTRA_OFFSET);
    end
  end

  // Result of the frame that ends with this byte.
  always_comb begin
    frame_ok = !too_long_d && (32'(pos_d) > ElemStart) && (32'(pos_d) <= MaxBytes);
    res_new.beacon_valid     = frame_ok;
    res_new.beacon_interval  = frame_ok ? interval_d : DEFAULT_INTERVAL;
    res_new.channel_found    = frame_ok && found_d[0];
    res_new.channel_addr     = (frame_ok && found_d[0]) ? chan_d : 16'd0;
    res_new.tim_found        = frame_ok && found_d[1];
    res_new.tim_offset       = (frame_ok && found_d[1]) ? tim_d : 9'd0;
    res_new.listen_interval  = (frame_ok && found_d[1]) ? listen_d : 8'd0;
    res_new.vendor_found     = frame_ok && found_d[2];
    res_new.vendor_info_addr = (frame_ok && found_d[2]) ? vaddr_d : 16'd0;
  end

  // Parser registers: advance on each transaction, clear after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      phase_q    <= PH_FIXED;
      type_q     <= '0;
      remain_q   <= '0;
      vstart_q   <= '0;
      vidx_q     <= '0;
      oui_q      <= 1'b1;
      interval_q <= '0;
      found_q    <= '0;
      chan_q     <= '0;
      tim_q      <= '0;
      listen_q   <= '0;
      vaddr_q    <= '0;
      too_long_q <= 1'b0;
      lpend_q    <= 1'b0;
      lpos_q     <= '0;
    end else if (accept) begin
      if (frame_last_i) begin
        pos_q      <= '0;
        phase_q    <= PH_FIXED;
        type_q     <= '0;
        remain_q   <= '0;
        vstart_q   <= '0;
        vidx_q     <= '0;
        oui_q      <= 1'b1;
        interval_q <= '0;
        found_q    <= '0;
        chan_q     <= '0;
        tim_q      <= '0;
        listen_q   <= '0;
        vaddr_q    <= '0;
        too_long_q <= 1'b0;
        lpend_q    <= 1'b0;
        lpos_q     <= '0;
      end else begin
        pos_q      <= pos_d;
        phase_q    <= phase_d;
        type_q     <= type_d;
        remain_q   <= remain_d;
        vstart_q   <= vstart_d;
        vidx_q     <= vidx_d;
        oui_q      <= oui_d;
        interval_q <= interval_d;
        found_q    <= found_d;
        chan_q     <= chan_d;
        tim_q      <= tim_d;
        listen_q   <= listen_d;
        vaddr_q    <= vaddr_d;
        too_long_q <= too_long_d;
        lpend_q    <= lpend_d;
        lpos_q     <= lpos_d;
      end
    end
  end

  // Output register with a skid slot; the input stalls only while the skid slot is full.
  assign out_ready = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept & frame_last_i;
      end
    end else if (accept && frame_last_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept && frame_last_i) begin
        out_q <= res_new;
      end
    end else if (accept && frame_last_i) begin
      skid_q <= res_new;
    end
  end

  // Output ports.
  assign out_valid_o        = out_valid_q;
  assign beacon_valid_o     = out_q.beacon_valid;
  assign beacon_interval_o  = out_q.beacon_interval;
  assign channel_found_o    = out_q.channel_found;
  assign channel_addr_o     = out_q.channel_addr;
  assign tim_found_o        = out_q.tim_found;
  assign tim_offset_o       = out_q.tim_offset;
  assign listen_interval_o  = out_q.listen_interval;
  assign vendor_found_o     = out_q.vendor_found;
  assign vendor_info_addr_o = out_q.vendor_info_addr;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the beacon element scanner.
// Drives stored beacon frames byte by byte, predicts each frame report and compares it.
// Depends on bes_pkg and beacon_element_scanner.
module tb;
  import bes_pkg::*;

  // Block configuration used for this run.
  localparam int TX_BYTES    = 12;
  localparam int MAC_BYTES   = 24;
  localparam int MAX_BYTES   = 512;
  localparam int VEND_MIN    = 8;
  localparam int VEND_EXTRA  = 4;

  // Frame layout derived from the configuration.
  localparam int HDR_BYTES   = TX_BYTES + MAC_BYTES;
  localparam int FIRST_ELEM  = HDR_BYTES + FIXED_FIELD_BYTES;
  localparam int INTERVAL_AT = (HDR_BYTES + INTERVAL_FIELD_OFS) & ~1;

  localparam logic [31:0] VENDOR_OUI = 32'h0009_BF00;
  localparam logic [7:0]  ID_FILLER  = 8'hAA;

  localparam int ITEM_TARGET       = 1700;
  localparam int MIN_RANDOM_FRAMES = 6;
  localparam int MAX_REPORTS       = 10;
  localparam int DRAIN_CYCLES      = 4;
  localparam int RUN_LIMIT         = 2_000_000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  frame_byte_i = '0;
  logic        frame_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        beacon_valid_o;
  logic [15:0] beacon_interval_o;
  logic        channel_found_o;
  logic [15:0] channel_addr_o;
  logic        tim_found_o;
  logic [8:0]  tim_offset_o;
  logic [7:0]  listen_interval_o;
  logic        vendor_found_o;
  logic [15:0] vendor_info_addr_o;

  beacon_element_scanner #(
    .TX_HEADER_BYTES    (TX_BYTES),
    .MAC_HEADER_BYTES   (MAC_BYTES),
    .MAX_FRAME_BYTES    (MAX_BYTES),
    .VENDOR_MIN_LEN     (VEND_MIN),
    .VENDOR_EXTRA_OFFSET(VEND_EXTRA)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .frame_byte_i      (frame_byte_i),
    .frame_last_i      (frame_last_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .beacon_valid_o    (beacon_valid_o),
    .beacon_interval_o (beacon_interval_o),
    .channel_found_o   (channel_found_o),
    .channel_addr_o    (channel_addr_o),
    .tim_found_o       (tim_found_o),
    .tim_offset_o      (tim_offset_o),
    .listen_interval_o (listen_interval_o),
    .vendor_found_o    (vendor_found_o),
    .vendor_info_addr_o(vendor_info_addr_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shared run state.
  res_t        beacon_reports[$];
  logic [7:0]  frame_q[$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  bit          quiet      = 1'b0;

  // Scanner state as the predictor sees it.
  logic [15:0] base_addr;
  logic [9:0]  byte_pos;
  phase_e      scan_phase;
  logic [7:0]  elem_id;
  logic [7:0]  elem_left;
  logic [9:0]  value_start;
  logic [7:0]  value_idx;
  logic        oui_ok;
  logic [15:0] interval_val;
  logic [2:0]  found;
  logic [15:0] chan_addr;
  logic [8:0]  tim_ofs;
  logic [7:0]  listen_val;
  logic [15:0] vend_addr;
  logic        too_long;
  logic        listen_wait;
  logic [9:0]  listen_at;

  function automatic logic [7:0] oui_at(input int idx);
    return VENDOR_OUI[8*(3-idx) +: 8];
  endfunction

  // Idle lengths: mostly none or short, a few long; none at all in quiet stretches.
  function automatic int unsigned pick_idle();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Parser returns here after reset and after every frame.
  function automatic void clear_scan();
    byte_pos     = '0;
    scan_phase   = PH_FIXED;
    elem_id      = '0;
    elem_left    = '0;
    value_start  = '0;
    value_idx    = '0;
    oui_ok       = 1'b1;
    interval_val = '0;
    found        = '0;
    chan_addr    = '0;
    tim_ofs      = '0;
    listen_val   = '0;
    vend_addr    = '0;
    too_long     = 1'b0;
    listen_wait  = 1'b0;
    listen_at    = '0;
  endfunction

  // An element header is complete: record where its value starts.
  function automatic void open_element(input logic [9:0] vstart, input logic [7:0] seglen);
    logic [9:0] rel;
    elem_left   = seglen;
    value_start = vstart;
    value_idx   = '0;
    oui_ok      = (seglen >= VEND_MIN);
    if (elem_id == ID_DS) begin
      found[0]  = 1'b1;
      chan_addr = base_addr + {6'd0, vstart};
    end else if (elem_id == ID_TIM) begin
      found[1]    = 1'b1;
      rel         = vstart - 10'(HDR_BYTES);
      tim_ofs     = rel[8:0];
      listen_val  = '0;
      listen_wait = 1'b1;
      listen_at   = vstart + 10'd1;
    end
    scan_phase = (elem_left != 0) ? PH_VALUE : PH_TYPE;
  endfunction

  function automatic void note_vendor_match();
    found[2]  = 1'b1;
    vend_addr = base_addr + {6'd0, value_start} + 16'(VEND_EXTRA);
  endfunction

  // One frame byte within the parsed range.
  function automatic void scan_byte(input logic [7:0] b);
    if (listen_wait && byte_pos == listen_at) begin
      listen_val  = b;
      listen_wait = 1'b0;
    end
    if (byte_pos == 10'(INTERVAL_AT)) interval_val[7:0] = b;
    if (byte_pos == 10'(INTERVAL_AT + 1)) interval_val[15:8] = b;
    case (scan_phase)
      PH_FIXED: begin
        if (int'(byte_pos) + 1 >= FIRST_ELEM) scan_phase = PH_TYPE;
      end
      PH_TYPE: begin
        elem_id    = b;
        scan_phase = PH_LEN;
      end
      PH_LEN: begin
        open_element(byte_pos + 10'd1, b);
      end
      default: begin
        if (elem_id == ID_VENDOR && value_idx < 8'd4) begin
          if (b != oui_at(int'(value_idx))) oui_ok = 1'b0;
          if (value_idx == 8'd3 && oui_ok) note_vendor_match();
        end
        if (value_idx != 8'd255) value_idx++;
        elem_left--;
        if (elem_left == 0) scan_phase = PH_TYPE;
      end
    endcase
  endfunction

  // Predict the effect of one accepted transaction; the last byte yields a report.
  function automatic void predict_beacon(input logic [7:0] b, input logic last);
    logic [9:0] count;
    logic       ok;
    res_t       r;
    if (int'(byte_pos) >= MAX_BYTES) too_long = 1'b1;
    else begin
      scan_byte(b);
      byte_pos++;
    end
    if (!last) return;
    count = byte_pos;
    if (!too_long) begin
      if (scan_phase == PH_LEN) begin
        open_element(count + 10'd1, 8'd0);
      end else if (scan_phase == PH_VALUE && elem_id == ID_VENDOR && oui_ok &&
                   value_idx == 8'd3) begin
        note_vendor_match();
      end
    end
    ok = !too_long && int'(count) > FIRST_ELEM && int'(count) <= MAX_BYTES;
    r.beacon_valid     = ok;
    r.beacon_interval  = ok ? interval_val : DEFAULT_INTERVAL;
    r.channel_found    = ok & found[0];
    r.channel_addr     = (ok && found[0]) ? chan_addr : 16'd0;
    r.tim_found        = ok & found[1];
    r.tim_offset       = (ok && found[1]) ? tim_ofs : 9'd0;
    r.listen_interval  = (ok && found[1]) ? listen_val : 8'd0;
    r.vendor_found     = ok & found[2];
    r.vendor_info_addr = (ok && found[2]) ? vend_addr : 16'd0;
    beacon_reports.push_back(r);
    clear_scan();
  endfunction

  // Frame builders.
  function automatic void begin_frame(input logic [15:0] interval);
    frame_q.delete();
    for (int i = 0; i < FIRST_ELEM; i++) frame_q.push_back(8'($urandom));
    frame_q[INTERVAL_AT]     = interval[7:0];
    frame_q[INTERVAL_AT + 1] = interval[15:8];
  endfunction

  function automatic void add_element(input logic [7:0] id, input logic [7:0] len);
    frame_q.push_back(id);
    frame_q.push_back(len);
    for (int i = 0; i < int'(len); i++) frame_q.push_back(8'($urandom));
  endfunction

  // Vendor element; bad_at names one OUI byte to corrupt, 4 or more for none.
  function automatic void add_vendor(input logic [7:0] len, input int bad_at);
    logic [7:0] b;
    frame_q.push_back(ID_VENDOR);
    frame_q.push_back(len);
    for (int i = 0; i < int'(len); i++) begin
      if (i < 4) begin
        b = oui_at(i);
        if (i == bad_at) b ^= 8'($urandom_range(1, 255));
      end else begin
        b = 8'($urandom);
      end
      frame_q.push_back(b);
    end
  endfunction

  // Fill with neutral elements up to exactly n bytes.
  function automatic void pad_frame(input int n);
    int rem;
    while (frame_q.size() < n) begin
      rem = n - frame_q.size();
      if (rem == 1) frame_q.push_back(ID_FILLER);
      else add_element(ID_FILLER, 8'((rem - 2 > 255) ? 255 : rem - 2));
    end
  endfunction

  function automatic void add_random_element();
    case ($urandom_range(0, 9))
      0, 1: add_element(ID_DS, ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 3)) : 8'd1);
      2, 3: add_element(ID_TIM, 8'($urandom_range(0, 8)));
      4, 5: add_vendor(8'($urandom_range(VEND_MIN, VEND_MIN + 6)), 4);
      6: begin
        if ($urandom_range(0, 1) != 0) add_vendor(8'($urandom_range(0, VEND_MIN - 1)), 4);
        else add_vendor(8'($urandom_range(VEND_MIN, VEND_MIN + 4)), $urandom_range(0, 3));
      end
      7: add_element(8'($urandom), 8'($urandom_range(0, 40)));
      default: add_element(8'($urandom), 8'($urandom_range(0, 10)));
    endcase
  endfunction

  // Mostly well-formed frames with random content, some cut short, some noise.
  function automatic void build_random_frame();
    int unsigned kind;
    int unsigned target;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      frame_q.delete();
      target = $urandom_range(1, 90);
      repeat (target) frame_q.push_back(8'($urandom));
      return;
    end
    if (kind < 11) target = $urandom_range(MAX_BYTES - 20, MAX_BYTES + 16);
    else if (kind < 16) target = $urandom_range(FIRST_ELEM - 12, FIRST_ELEM);
    else target = $urandom_range(FIRST_ELEM + 1, FIRST_ELEM + 32);
    begin_frame(16'($urandom));
    while (frame_q.size() < target) add_random_element();
    if ($urandom_range(0, 2) == 0 || target <= FIRST_ELEM) begin
      while (frame_q.size() > target) void'(frame_q.pop_back());
    end
  endfunction

  // Send one frame byte as a transaction and predict once it is accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = pick_idle();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    frame_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_beacon(b, last);
    items_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Hold the sender off until every pending report has arrived.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (beacon_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_base_addr(input logic [15:0] addr);
    drain_reports();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    base_addr   = addr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Frames at and around the minimum length.
  task automatic test_minimal_frames();
    frame_q.delete();
    frame_q.push_back(8'($urandom));
    send_frame();
    begin_frame(16'h0000);
    send_frame();
    begin_frame(16'hFFFF);
    frame_q.push_back(ID_FILLER);
    send_frame();
    begin_frame(16'h1234);
    add_element(ID_DS, 8'd1);
    send_frame();
  endtask

  // Frames at the buffer limit and beyond it.
  task automatic test_length_limits();
    // DS type byte as the very last byte of a maximum-size frame.
    begin_frame(16'($urandom));
    add_element(ID_TIM, 8'd4);
    add_vendor(8'd8, 4);
    pad_frame(MAX_BYTES - 1);
    frame_q.push_back(ID_DS);
    send_frame();
    // One byte more than the buffer holds.
    begin_frame(16'($urandom));
    add_element(ID_DS, 8'd1);
    add_vendor(8'd10, 4);
    pad_frame(MAX_BYTES + 1);
    send_frame();
  endtask

  // Each element kind, repeated elements and a short TIM.
  task automatic test_element_kinds();
    begin_frame(16'($urandom));
    add_element(ID_DS, 8'd1);
    add_element(ID_TIM, 8'd4);
    add_vendor(8'd10, 4);
    send_frame();
    begin_frame(16'($urandom));
    add_vendor(8'd9, 4);
    add_vendor(8'd9, 2);
    add_vendor(8'd7, 4);
    add_element(ID_DS, 8'd1);
    add_element(ID_DS, 8'd2);
    add_element(ID_TIM, 8'd1);
    add_element(ID_DS, 8'd1);
    send_frame();
    begin_frame(16'($urandom));
    add_element(ID_FILLER, 8'd255);
    add_element(ID_TIM, 8'd0);
    add_element(ID_FILLER, 8'd3);
    send_frame();
  endtask

  // Frames that end inside an element.
  task automatic test_frame_end_cases();
    begin_frame(16'($urandom));
    add_element(ID_FILLER, 8'd2);
    frame_q.push_back(ID_DS);
    send_frame();
    begin_frame(16'($urandom));
    frame_q.push_back(ID_TIM);
    send_frame();
    begin_frame(16'($urandom));
    frame_q.push_back(ID_TIM);
    frame_q.push_back(8'd4);
    send_frame();
    begin_frame(16'($urandom));
    frame_q.push_back(ID_TIM);
    frame_q.push_back(8'd3);
    frame_q.push_back(8'($urandom));
    send_frame();
    // Vendor cut off after three OUI bytes still matches.
    begin_frame(16'($urandom));
    add_vendor(8'd8, 4);
    repeat (5) void'(frame_q.pop_back());
    send_frame();
    begin_frame(16'($urandom));
    add_vendor(8'd8, 4);
    repeat (6) void'(frame_q.pop_back());
    send_frame();
  endtask

  // Address wrap at the top of the base address range.
  task automatic test_base_address_extremes();
    logic [15:0] bases[3];
    bases = '{16'hFFFF, 16'h0000, 16'h8000};
    foreach (bases[k]) begin
      set_base_addr(bases[k]);
      begin_frame(16'($urandom));
      add_element(ID_DS, 8'd1);
      add_element(ID_TIM, 8'd2);
      add_vendor(8'd12, 4);
      send_frame();
    end
  endtask

  // Frames sent and collected with no idle cycles at all.
  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (4) begin
      build_random_frame();
      send_frame();
    end
    quiet = 1'b0;
  endtask

  // Random frames until the run has sent its share of transactions.
  task automatic test_random_frames();
    int unsigned frames;
    frames = 0;
    while (items_sent < ITEM_TARGET || frames < MIN_RANDOM_FRAMES) begin
      if (frames % 8 == 7) begin
        case ($urandom_range(0, 3))
          0: set_base_addr(16'h0000);
          1: set_base_addr(16'hFFFF);
          default: set_base_addr(16'($urandom));
        endcase
      end
      quiet = ($urandom_range(0, 6) == 0);
      build_random_frame();
      send_frame();
      frames++;
    end
    quiet = 1'b0;
  endtask

  // Receiver back-pressure with random stall lengths.
  initial begin : stall_driver
    int unsigned hold;
    forever begin
      @(posedge clk_i);
      out_stall_i <= 1'b0;
      repeat (pick_idle() + 1) @(posedge clk_i);
      hold = pick_idle();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Compare every accepted report with the oldest prediction.
  always @(posedge clk_i) begin : check_reports
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (beacon_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("report received with no frame pending");
      end else begin
        want = beacon_reports.pop_front();
        check_field("beacon_valid", 16'(want.beacon_valid), 16'(beacon_valid_o));
        check_field("beacon_interval", want.beacon_interval, beacon_interval_o);
        check_field("channel_found", 16'(want.channel_found), 16'(channel_found_o));
        check_field("channel_addr", want.channel_addr, channel_addr_o);
        check_field("tim_found", 16'(want.tim_found), 16'(tim_found_o));
        check_field("tim_offset", 16'(want.tim_offset), 16'(tim_offset_o));
        check_field("listen_interval", 16'(want.listen_interval), 16'(listen_interval_o));
        check_field("vendor_found", 16'(want.vendor_found), 16'(vendor_found_o));
        check_field("vendor_info_addr", want.vendor_info_addr, vendor_info_addr_o);
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : run_tests
    base_addr = '0;
    clear_scan();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_minimal_frames();
    test_length_limits();
    test_element_kinds();
    test_frame_end_cases();
    test_base_address_extremes();
    test_back_to_back();
    test_random_frames();
    drain_reports();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && beacon_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
